@@ design/erf_pkg.sv @@
// Shared widths, coefficients and transfer types for the error function unit.
`default_nettype none

package erf_pkg;

  localparam int XW   = 32;
  localparam int ZW   = 39;
  localparam int TW   = 31;
  localparam int PW   = 36;
  localparam int AW   = 41;
  localparam int RW   = 30;
  localparam int SUMW = 32;
  localparam int EW   = 33;
  localparam int NH   = 9;
  localparam int EQB  = 6;
  localparam int NTERMS = 13;

  localparam logic [RW-1:0] LN2_Q30 = 30'd744261118;

  localparam longint CV0 = (64'sd126551223 * 64'sd1073741824 + 64'sd50000000) / 64'sd100000000;
  localparam longint CV1 = (64'sd100002368 * 64'sd1073741824 + 64'sd50000000) / 64'sd100000000;
  localparam longint CV2 = (64'sd37409196 * 64'sd1073741824 + 64'sd50000000) / 64'sd100000000;
  localparam longint CV3 = (64'sd9678418 * 64'sd1073741824 + 64'sd50000000) / 64'sd100000000;
  localparam longint CV4 = (64'sd18628806 * 64'sd1073741824 + 64'sd50000000) / 64'sd100000000;
  localparam longint CV5 = (64'sd27886807 * 64'sd1073741824 + 64'sd50000000) / 64'sd100000000;
  localparam longint CV6 = (64'sd113520398 * 64'sd1073741824 + 64'sd50000000) / 64'sd100000000;
  localparam longint CV7 = (64'sd148851587 * 64'sd1073741824 + 64'sd50000000) / 64'sd100000000;
  localparam longint CV8 = (64'sd82215223 * 64'sd1073741824 + 64'sd50000000) / 64'sd100000000;
  localparam longint CV9 = (64'sd17087277 * 64'sd1073741824 + 64'sd50000000) / 64'sd100000000;

  typedef logic signed [PW-1:0] coef_t;

  localparam coef_t COEF [10] = '{
    coef_t'(CV0), coef_t'(CV1), coef_t'(CV2), coef_t'(CV3), coef_t'(-CV4),
    coef_t'(CV5), coef_t'(-CV6), coef_t'(CV7), coef_t'(-CV8), coef_t'(CV9)
  };

  typedef struct packed {
    logic          op;
    logic          neg;
    logic [ZW-1:0] zz;
  } erf_tag_t;

  typedef struct packed {
    logic          op;
    logic          neg;
    logic [TW-1:0] t;
  } erf_ctx_t;

endpackage

`default_nettype wire

@@ design/erf_recip.sv @@
// Pipelined restoring divider forming t = round(2^58 / (2^28 + z)), one quotient bit per stage.
`default_nettype none

module erf_recip
  import erf_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [XW-1:0] z_i,
  input  erf_tag_t      tag_i,
  output logic          valid_o,
  output logic [TW-1:0] t_o,
  output erf_tag_t      tag_o
);

  localparam int NST = TW + 1;
  localparam int NW  = 59;

  logic          v_q   [NST];
  logic [XW-1:0] d_q   [NST];
  logic [XW-1:0] rem_q [NST];
  logic [TW-1:0] num_q [NST];
  logic [TW-1:0] quo_q [NST];
  erf_tag_t      tag_q [NST];

  logic [XW-1:0] d0;
  logic [NW-1:0] num0;

  assign d0   = z_i + (XW'(1) << 28);
  assign num0 = (NW'(1) << 58) + NW'(d0 >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q[0]   <= d0;
    rem_q[0] <= XW'(num0[NW-1:TW]);
    num_q[0] <= num0[TW-1:0];
    quo_q[0] <= '0;
    tag_q[0] <= tag_i;
  end

  for (genvar j = 1; j < NST; j++) begin : g_step
    logic [XW:0] sh;
    logic [XW:0] diff;
    logic        ge;

    assign sh   = {rem_q[j-1], num_q[j-1][TW-1]};
    assign diff = sh - {1'b0, d_q[j-1]};
    assign ge   = !diff[XW];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else begin
        v_q[j] <= v_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      d_q[j]   <= d_q[j-1];
      rem_q[j] <= ge ? diff[XW-1:0] : sh[XW-1:0];
      num_q[j] <= num_q[j-1] << 1;
      quo_q[j] <= {quo_q[j-1][TW-2:0], ge};
      tag_q[j] <= tag_q[j-1];
    end
  end

  assign valid_o = v_q[NST-1];
  assign t_o     = quo_q[NST-1];
  assign tag_o   = tag_q[NST-1];

endmodule

`default_nettype wire

@@ design/erf_exp.sv @@
// Pipelined Q30 exponential: ln2 range reduction, 13-term Taylor sum, power-of-two scaling.
`default_nettype none

module erf_exp
  import erf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [AW-1:0] arg_i,
  input  erf_ctx_t             ctx_i,
  output logic                 valid_o,
  output logic [EW-1:0]        e_o,
  output erf_ctx_t             ctx_o
);

  localparam int DW  = 36;
  localparam int PRW = TW + RW;
  localparam int MW  = TW + 33;
  localparam int CW  = TW + 4;
  localparam logic [AW-1:0]  ZLIM = AW'(LN2_Q30) * AW'((1 << EQB) - 1);
  localparam logic [EQB-1:0] SMAX = '1;

  typedef struct packed {
    logic [RW-1:0]   r;
    logic [EQB-1:0]  s;
    logic            neg;
    logic            zero;
    erf_ctx_t        ctx;
    logic [SUMW-1:0] sum;
  } car_t;

  // range reduction
  logic           dv_q   [EQB+1];
  logic           dneg_q [EQB+1];
  logic           dbig_q [EQB+1];
  logic [DW-1:0]  drem_q [EQB+1];
  logic [EQB-1:0] dquo_q [EQB+1];
  erf_ctx_t       dctx_q [EQB+1];

  logic [AW-1:0] mag;
  logic          big;

  assign mag = arg_i[AW-1] ? AW'(-arg_i) : AW'(arg_i);
  assign big = arg_i[AW-1] && (mag >= ZLIM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else begin
      dv_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dneg_q[0] <= arg_i[AW-1];
    dbig_q[0] <= big;
    drem_q[0] <= big ? '0 : mag[DW-1:0];
    dquo_q[0] <= '0;
    dctx_q[0] <= ctx_i;
  end

  for (genvar j = 1; j <= EQB; j++) begin : g_div
    localparam logic [DW-1:0] DV = DW'(LN2_Q30) << (EQB - j);
    logic ge;

    assign ge = drem_q[j-1] >= DV;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j] <= 1'b0;
      end else begin
        dv_q[j] <= dv_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      dneg_q[j] <= dneg_q[j-1];
      dbig_q[j] <= dbig_q[j-1];
      drem_q[j] <= ge ? drem_q[j-1] - DV : drem_q[j-1];
      dquo_q[j] <= {dquo_q[j-1][EQB-2:0], ge};
      dctx_q[j] <= dctx_q[j-1];
    end
  end

  // Taylor series
  logic          e_v_q    [NTERMS+1];
  car_t          e_c_q    [NTERMS+1];
  logic [TW-1:0] e_term_q [NTERMS+1];

  logic          a_v_q    [1:NTERMS];
  car_t          a_c_q    [1:NTERMS];
  logic [PRW-1:0] a_prod_q [1:NTERMS];

  logic          b_v_q    [1:NTERMS];
  car_t          b_c_q    [1:NTERMS];
  logic [TW-1:0] b_y_q    [1:NTERMS];
  logic [TW-1:0] b_q0_q   [1:NTERMS];

  car_t           setup;
  logic [RW-1:0]  rem_lo;
  logic [EQB-1:0] quo;

  always_comb begin
    rem_lo     = drem_q[EQB][RW-1:0];
    quo        = dquo_q[EQB];
    setup.neg  = dneg_q[EQB];
    setup.ctx  = dctx_q[EQB];
    setup.sum  = SUMW'(1) << 30;
    if (!dneg_q[EQB] || rem_lo == '0) begin
      setup.s = quo;
      setup.r = rem_lo;
    end else begin
      setup.s = quo + EQB'(1);
      setup.r = LN2_Q30 - rem_lo;
    end
    setup.zero = dbig_q[EQB] || (dneg_q[EQB] && setup.s == SMAX);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q[0] <= 1'b0;
    end else begin
      e_v_q[0] <= dv_q[EQB];
    end
  end

  always_ff @(posedge clk_i) begin
    e_c_q[0]    <= setup;
    e_term_q[0] <= TW'(1) << 30;
  end

  for (genvar k = 1; k <= NTERMS; k++) begin : g_term
    localparam logic [32:0] RCP = 33'((64'd1 << 32) / k);
    logic [PRW-1:0] ysum;
    logic [MW-1:0]  q0p;
    logic [CW-1:0]  qk;
    logic [CW-1:0]  rr;
    logic [TW-1:0]  tnew;
    car_t           cnew;

    assign ysum = a_prod_q[k] + (PRW'(k) << 29);
    assign q0p  = MW'(ysum[PRW-1:30]) * MW'(RCP);
    assign qk   = CW'(b_q0_q[k]) * CW'(k);
    assign rr   = CW'(b_y_q[k]) - qk;
    assign tnew = b_q0_q[k] + TW'(rr >= CW'(k));

    always_comb begin
      cnew     = b_c_q[k];
      cnew.sum = b_c_q[k].sum + SUMW'(tnew);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        a_v_q[k] <= 1'b0;
        b_v_q[k] <= 1'b0;
        e_v_q[k] <= 1'b0;
      end else begin
        a_v_q[k] <= e_v_q[k-1];
        b_v_q[k] <= a_v_q[k];
        e_v_q[k] <= b_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      a_c_q[k]    <= e_c_q[k-1];
      a_prod_q[k] <= PRW'(e_term_q[k-1]) * PRW'(e_c_q[k-1].r);
      b_c_q[k]    <= a_c_q[k];
      b_y_q[k]    <= ysum[PRW-1:30];
      b_q0_q[k]   <= q0p[32+TW-1:32];
      e_c_q[k]    <= cnew;
      e_term_q[k] <= tnew;
    end
  end

  // scaling by 2^n
  car_t            fin;
  logic [2*SUMW-1:0] wide;
  logic [EW-1:0]   e_d;
  logic            ov_q;
  logic [EW-1:0]   oe_q;
  erf_ctx_t        octx_q;

  assign fin  = e_c_q[NTERMS];
  assign wide = {fin.sum, SUMW'(0)} >> fin.s;

  always_comb begin
    if (fin.zero) begin
      e_d = '0;
    end else if (!fin.neg) begin
      e_d = EW'(fin.sum) << fin.s;
    end else begin
      e_d = EW'(wide[2*SUMW-1:SUMW]) + EW'(wide[SUMW-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= e_v_q[NTERMS];
    end
  end

  always_ff @(posedge clk_i) begin
    oe_q   <= e_d;
    octx_q <= fin.ctx;
  end

  assign valid_o = ov_q;
  assign e_o     = oe_q;
  assign ctx_o   = octx_q;

endmodule

`default_nettype wire

@@ design/error_function_unit.sv @@
// Top level of the error function unit: erfc(x) or erf(x) of a Q4.27 argument, Q1.30 result.
// Throughput: one transfer per cycle; busy stays low, every stage advances each cycle.
// Cost is set by the reciprocal divider and the 13 three-stage Taylor terms.
// Reset clears only the stage valid bits; no result is presented until a new transfer.
`default_nettype none

module error_function_unit
  import erf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 opcode_i,
  input  logic signed [XW-1:0] x_value_i,
  output logic                 done_o,
  output logic signed [XW-1:0] func_value_o
);

  localparam int LAT = 3 + (TW + 1) + 2 * NH + (EQB + 2 + 3 * NTERMS + 1) + 2;
  localparam int MPW = PW + TW;
  localparam int VW  = 36;
  localparam logic signed [AW-1:0] ARG_MAX = AW'(2 ** 30);
  localparam logic signed [VW-1:0] TWO_Q30 = VW'(1) << 31;
  localparam logic signed [VW-1:0] ONE_Q30 = VW'(1) << 30;
  localparam logic signed [VW-1:0] MAXV    = TWO_Q30 - VW'(1);
  localparam logic signed [VW-1:0] MINV    = -TWO_Q30;

  assign busy = 1'b0;

  // front end: magnitude and z*z
  logic            s0v_q, s1v_q, s2v_q;
  logic [XW-1:0]   s0z_q, s1z_q, s2z_q;
  logic            s0op_q, s1op_q, s0neg_q, s1neg_q;
  logic [2*XW-1:0] s1sq_q;
  erf_tag_t        s2tag_q;
  logic [2*XW-1:0] sq_rnd;

  assign sq_rnd = s1sq_q + ((2 * XW)'(1) << 23);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0v_q <= 1'b0;
      s1v_q <= 1'b0;
      s2v_q <= 1'b0;
    end else begin
      s0v_q <= start && !busy;
      s1v_q <= s0v_q;
      s2v_q <= s1v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s0z_q       <= x_value_i[XW-1] ? XW'(-x_value_i) : XW'(x_value_i);
    s0neg_q     <= x_value_i[XW-1];
    s0op_q      <= opcode_i;
    s1z_q       <= s0z_q;
    s1sq_q      <= (2 * XW)'(s0z_q) * (2 * XW)'(s0z_q);
    s1neg_q     <= s0neg_q;
    s1op_q      <= s0op_q;
    s2z_q       <= s1z_q;
    s2tag_q.op  <= s1op_q;
    s2tag_q.neg <= s1neg_q;
    s2tag_q.zz  <= sq_rnd[ZW+23:24];
  end

  // reciprocal
  logic          rv;
  logic [TW-1:0] rt;
  erf_tag_t      rtag;

  erf_recip u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2v_q),
    .z_i     (s2z_q),
    .tag_i   (s2tag_q),
    .valid_o (rv),
    .t_o     (rt),
    .tag_o   (rtag)
  );

  // Horner evaluation in t
  logic           mv_q   [NH];
  logic [MPW-1:0] mmag_q [NH];
  logic           mneg_q [NH];
  logic [TW-1:0]  mt_q   [NH];
  erf_tag_t       mtag_q [NH];

  logic                 av_q   [NH-1];
  logic signed [PW-1:0] ap_q   [NH-1];
  logic [TW-1:0]        at_q   [NH-1];
  erf_tag_t             atag_q [NH-1];

  logic                 argv_q;
  logic signed [AW-1:0] arg_q;
  erf_ctx_t             argctx_q;

  for (genvar i = 0; i < NH; i++) begin : g_horner
    logic                 v_in;
    logic signed [PW-1:0] p_in;
    logic [TW-1:0]        t_in;
    erf_tag_t             tag_in;
    logic [PW-1:0]        pmag;
    logic [MPW-1:0]       rnd;
    logic [PW-1:0]        rmag;
    logic signed [PW-1:0] sr;

    if (i == 0) begin : g_first
      assign v_in   = rv;
      assign p_in   = COEF[NH];
      assign t_in   = rt;
      assign tag_in = rtag;
    end else begin : g_next
      assign v_in   = av_q[i-1];
      assign p_in   = ap_q[i-1];
      assign t_in   = at_q[i-1];
      assign tag_in = atag_q[i-1];
    end

    assign pmag = p_in[PW-1] ? PW'(-p_in) : PW'(p_in);
    assign rnd  = mmag_q[i] + (MPW'(1) << 29);
    assign rmag = rnd[PW+29:30];
    assign sr   = mneg_q[i] ? -$signed(rmag) : $signed(rmag);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mv_q[i] <= 1'b0;
      end else begin
        mv_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      mmag_q[i] <= MPW'(pmag) * MPW'(t_in);
      mneg_q[i] <= p_in[PW-1];
      mt_q[i]   <= t_in;
      mtag_q[i] <= tag_in;
    end

    if (i < NH - 1) begin : g_acc
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          av_q[i] <= 1'b0;
        end else begin
          av_q[i] <= mv_q[i];
        end
      end

      always_ff @(posedge clk_i) begin
        ap_q[i]   <= COEF[NH-1-i] + sr;
        at_q[i]   <= mt_q[i];
        atag_q[i] <= mtag_q[i];
      end
    end else begin : g_arg
      logic signed [AW-1:0] asum;

      assign asum = AW'(sr) - $signed(AW'(mtag_q[i].zz)) - AW'(COEF[0]);

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          argv_q <= 1'b0;
        end else begin
          argv_q <= mv_q[i];
        end
      end

      always_ff @(posedge clk_i) begin
        arg_q        <= (asum > ARG_MAX) ? ARG_MAX : asum;
        argctx_q.op  <= mtag_q[i].op;
        argctx_q.neg <= mtag_q[i].neg;
        argctx_q.t   <= mt_q[i];
      end
    end
  end

  // exponential
  logic          ev;
  logic [EW-1:0] ee;
  erf_ctx_t      ectx;

  erf_exp u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (argv_q),
    .arg_i   (arg_q),
    .ctx_i   (argctx_q),
    .valid_o (ev),
    .e_o     (ee),
    .ctx_o   (ectx)
  );

  // t * exp, reflection, erf, saturation
  logic               f1v_q, f1op_q, f1neg_q;
  logic [TW+EW-1:0]   f1prod_q;
  logic [TW+EW-1:0]   frnd;
  logic signed [VW-1:0] ecs, val, res;
  logic               done_q;
  logic [XW-1:0]      func_q;

  always_comb begin
    frnd = f1prod_q + ((TW + EW)'(1) << 29);
    ecs  = $signed(VW'(frnd[TW+EW-1:30]));
    val  = f1neg_q ? TWO_Q30 - ecs : ecs;
    res  = f1op_q ? ONE_Q30 - val : val;
    if (res > MAXV) begin
      res = MAXV;
    end else if (res < MINV) begin
      res = MINV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1v_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      f1v_q  <= ev;
      done_q <= f1v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f1prod_q <= (TW + EW)'(ectx.t) * (TW + EW)'(ee);
    f1op_q   <= ectx.op;
    f1neg_q  <= ectx.neg;
    func_q   <= res[XW-1:0];
  end

  assign done_o       = done_q;
  assign func_value_o = $signed(func_q);

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##LAT done_o)
    else $error("result strobe missing after fixed latency");

  a_erfc_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !$past(opcode_i, LAT) |-> !func_value_o[XW-1])
    else $error("erfc result negative");

  a_erf_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(opcode_i, LAT) |->
      (func_value_o <= 32'sd1073741824) && (func_value_o >= -32'sd1073741824))
    else $error("erf result outside [-1, 1]");

endmodule

`default_nettype wire

@@ verif/error_function_unit_tb.sv @@
// Self-checking testbench for the error function unit: directed and random arguments.
`default_nettype none

class erf_scoreboard;
  logic [31:0] pending_q[$];
  int          mismatches;
  int          failures;

  function automatic longint coef(int i);
    longint dec[10] = '{126551223, 100002368, 37409196, 9678418, -18628806,
                        27886807, -113520398, 148851587, -82215223, 17087277};
    longint m;
    m = dec[i] < 0 ? -dec[i] : dec[i];
    m = (m * 64'sd1073741824 + 64'sd50000000) / 64'sd100000000;
    return dec[i] < 0 ? -m : m;
  endfunction

  function automatic longint mul_t(longint a, bit [63:0] t);
    bit [63:0] m;
    bit [63:0] r;
    m = a < 0 ? -a : a;
    r = (m * t + (64'd1 << 29)) >> 30;
    return a < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic bit [63:0] exp_fixed(longint a);
    longint    ln2;
    longint    n;
    bit [63:0] r, sum, term, kk, s;
    ln2 = 744261118;
    if (a >= 0) begin
      n = a / ln2;
    end else begin
      n = -longint'((64'(-a) + ln2 - 1) / ln2);
    end
    r = 64'(a - n * ln2);
    sum = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int k = 1; k <= 13; k++) begin
      kk = 64'(k);
      term = (term * r + (kk << 29)) / (kk << 30);
      sum += term;
    end
    if (n >= 0) return sum << n;
    s = -n;
    if (s >= 63) return '0;
    return (sum + (64'd1 << (s - 1))) >> s;
  endfunction

  function automatic logic [31:0] erf_value(bit op, logic [31:0] xv);
    bit        neg;
    bit [63:0] z, d, t, zz, e, ec;
    longint    p, arg, val, res;
    neg = xv[31];
    z = neg ? (64'h1_0000_0000 - 64'(xv)) : 64'(xv);
    d = (64'd1 << 28) + z;
    t = ((64'd1 << 58) + (d >> 1)) / d;
    zz = (z * z + (64'd1 << 23)) >> 24;
    p = coef(9);
    for (int k = 8; k >= 1; k--) p = coef(k) + mul_t(p, t);
    arg = -longint'(zz) - coef(0) + mul_t(p, t);
    if (arg > 64'sd1073741824) arg = 64'sd1073741824;
    e = exp_fixed(arg);
    ec = (t * e + (64'd1 << 29)) >> 30;
    val = neg ? (64'sd1 << 31) - longint'(ec) : longint'(ec);
    res = op ? 64'sd1073741824 - val : val;
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    return res[31:0];
  endfunction

  function void note_transfer(bit op, logic [31:0] xv);
    pending_q.push_back(erf_value(op, xv));
  endfunction

  function void check_result(logic [31:0] got);
    logic [31:0] want;
    if (pending_q.size() == 0) begin
      failures++;
      $display("unexpected result %h", got);
      return;
    end
    want = pending_q.pop_front();
    if (got !== want) begin
      failures++;
      mismatches++;
      if (mismatches <= 10) $display("func_value mismatch: expected %h, got %h", want, got);
    end
  endfunction
endclass

module error_function_unit_tb;
  import erf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 opcode_i = 1'b0;
  logic signed [XW-1:0] x_value_i = '0;
  logic                 done_o;
  logic signed [XW-1:0] func_value_o;

  erf_scoreboard sb = new();
  int            idle_pct;
  int            quiet_cycles;

  error_function_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .opcode_i(opcode_i), .x_value_i(x_value_i),
    .done_o(done_o), .func_value_o(func_value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        sb.note_transfer(opcode_i, x_value_i);
      end
      if (done_o) begin
        sb.check_result(func_value_o);
      end
      if ((start && !busy) || done_o) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles > 2000) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_arg(bit op, logic [31:0] xv);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    opcode_i <= op;
    x_value_i <= xv;
    do @(posedge clk_i); while (busy);
  endtask

  function automatic logic [31:0] rand_arg();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom_range(32'h2000_0000);
      2:       return -$urandom_range(32'h2000_0000);
      default: return $signed($urandom_range(4095)) - 2048;
    endcase
  endfunction

  initial begin
    logic [31:0] directed[$] = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'hffff_ffff,
                                 32'h0800_0000, 32'hf800_0000, 32'h1000_0000, 32'hf000_0000,
                                 32'h3000_0000, 32'hd000_0000};
    quiet_cycles = 0;
    idle_pct = 30;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      send_arg(1'b0, directed[i]);
      send_arg(1'b1, directed[i]);
    end
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 30 : (ph == 1) ? 45 : 0;
      for (int i = 0; i < 200; i++) begin
        send_arg(1'($urandom_range(1)), rand_arg());
        if (ph == 1 && i == 100) begin
          start <= 1'b0;
          @(posedge clk_i);
          while (sb.pending_q.size() != 0) @(posedge clk_i);
        end
      end
    end
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

`default_nettype wire
